// ----- design/ezyx_pkg.sv -----
// ----------------------------------------------------------------------------
// ezyx_pkg
// Shared types, constants and helpers for the Euler ZYX to rotation matrix unit.
// ----------------------------------------------------------------------------
package ezyx_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int OUT_FRAC_BITS = 14;
    localparam int CORDIC_STEPS  = 31;
    localparam int XY_BITS       = 33;
    localparam int Z_BITS        = 33;

    localparam logic signed [XY_BITS-1:0] CORDIC_GAIN = 33'sd652032874;

    typedef struct packed {
        logic signed [15:0] yaw_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
    } ezyx_in_t;

    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [15:0] r10;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
    } ezyx_out_t;

    // Arctangent of 2^-i, 2^32 per turn.
    function automatic logic signed [Z_BITS-1:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        begin
            case (i)
                5'd0:  v = 32'h20000000;
                5'd1:  v = 32'h12E4051E;
                5'd2:  v = 32'h09FB385B;
                5'd3:  v = 32'h051111D4;
                5'd4:  v = 32'h028B0D43;
                5'd5:  v = 32'h0145D7E1;
                5'd6:  v = 32'h00A2F61E;
                5'd7:  v = 32'h00517C55;
                5'd8:  v = 32'h0028BE53;
                5'd9:  v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;
                5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;
                5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2FA;
                5'd15: v = 32'h0000517D;
                5'd16: v = 32'h000028BE;
                5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A30;
                5'd19: v = 32'h00000518;
                5'd20: v = 32'h0000028C;
                5'd21: v = 32'h00000146;
                5'd22: v = 32'h000000A3;
                5'd23: v = 32'h00000051;
                5'd24: v = 32'h00000029;
                5'd25: v = 32'h00000014;
                5'd26: v = 32'h0000000A;
                5'd27: v = 32'h00000005;
                5'd28: v = 32'h00000003;
                5'd29: v = 32'h00000001;
                5'd30: v = 32'h00000001;
                default: v = 32'h0;
            endcase
            atan_lut = $signed({1'b0, v});
        end
    endfunction

    // Q30 product rounded half up back to Q30.
    function automatic logic signed [XY_BITS-1:0] mul_q30(
        input logic signed [XY_BITS-1:0] a,
        input logic signed [XY_BITS-1:0] b
    );
        logic signed [2*XY_BITS-1:0] p;
        begin
            p = a * b + (66'sd1 <<< 29);
            mul_q30 = XY_BITS'(p >>> 30);
        end
    endfunction

    // Round Q30 to output fraction, saturate to +-1.0.
    function automatic logic signed [15:0] to_out(input logic signed [XY_BITS:0] v);
        logic signed [XY_BITS:0] r;
        logic signed [XY_BITS:0] lim;
        begin
            lim = (XY_BITS+1)'(1) <<< OUT_FRAC_BITS;
            r = (v + ((XY_BITS+1)'(1) <<< (29 - OUT_FRAC_BITS))) >>> (30 - OUT_FRAC_BITS);
            if (r > lim)
                r = lim;
            if (r < -lim)
                r = -lim;
            to_out = r[15:0];
        end
    endfunction

endpackage

// ----- design/euler_zyx_to_rotation_matrix_unit.sv -----
// ----------------------------------------------------------------------------
// euler_zyx_to_rotation_matrix_unit
// Yaw/pitch/roll binary angles to the 3x3 rotation matrix Rz*Ry*Rx in Q1.14.
// ----------------------------------------------------------------------------
// Usage: present an angle triple on in_data with in_valid; it is taken as a
// transaction when in_valid and in_ready are both high. Each transaction
// yields exactly one matrix on out_data with out_valid, taken when out_ready
// is high.
// Pipeline: 1 angle fold stage, 31 CORDIC stages (one rotation each),
// 4 product/sum stages, all registered between acceptance and out_valid.
// Throughput is one transaction per cycle unless stalled; every stage advances together.
// Stall: when out_valid is high and out_ready low the whole pipeline holds
// (in_ready drops); nothing is lost or repeated. The pipeline advances
// whenever its last stage is empty or being drained; bubbles inside it are
// kept while it holds.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers are
// not reset.
// ----------------------------------------------------------------------------
module euler_zyx_to_rotation_matrix_unit
    import ezyx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ezyx_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output ezyx_out_t out_data
);

    localparam int NSTG = CORDIC_STEPS + 5;

    logic [NSTG-1:0] vld_reg;
    logic            adv;

    assign adv      = !vld_reg[NSTG-1] || out_ready;
    assign in_ready = adv;
    assign out_valid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
    end

    // Stage 0: fold angle into [-pi/2, pi/2).
    logic signed [2:0][XY_BITS-1:0] x0_reg, y0_reg, x_end, y_end;
    logic signed [2:0][Z_BITS-1:0]  z0_reg;
    logic        [2:0]              f0_reg, f_end;
    logic [2:0][ANGLE_BITS-1:0] ang;
    logic [2:0][31:0] u;
    logic [2:0] flp;

    assign ang[0] = in_data.yaw_angle;
    assign ang[1] = in_data.pitch_angle;
    assign ang[2] = in_data.roll_angle;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            u[k]   = {ang[k], {(32-ANGLE_BITS){1'b0}}};
            flp[k] = u[k][31] ^ u[k][30];
            if (flp[k])
                u[k] = u[k] + 32'h80000000;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                x0_reg[k] <= CORDIC_GAIN;
                y0_reg[k] <= '0;
                z0_reg[k] <= {u[k][31], u[k]};
                f0_reg[k] <= flp[k];
            end
        end
    end

    ezyx_cordic_stage u_cordic (
        .clk      (clk),
        .en       (adv),
        .x_in     (x0_reg),
        .y_in     (y0_reg),
        .z_in     (z0_reg),
        .flip_in  (f0_reg),
        .x_out    (x_end),
        .y_out    (y_end),
        .flip_out (f_end)
    );

    // Apply flip: cos/sin of each angle.
    logic signed [XY_BITS-1:0] ca, sa, cb, sb, cc, sc;
    assign ca = f_end[0] ? -x_end[0] : x_end[0];
    assign sa = f_end[0] ? -y_end[0] : y_end[0];
    assign cb = f_end[1] ? -x_end[1] : x_end[1];
    assign sb = f_end[1] ? -y_end[1] : y_end[1];
    assign cc = f_end[2] ? -x_end[2] : x_end[2];
    assign sc = f_end[2] ? -y_end[2] : y_end[2];

    // Product stage 1: pairwise products.
    logic signed [XY_BITS-1:0] p_cacb_reg, p_sacb_reg, p_casb_reg, p_sasb_reg;
    logic signed [XY_BITS-1:0] p_sacc_reg, p_sasc_reg, p_cacc_reg, p_casc_reg;
    logic signed [XY_BITS-1:0] p_cbsc_reg, p_cbcc_reg, nsb_reg;
    logic signed [XY_BITS-1:0] c1_sc_reg, c1_cc_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_cacb_reg <= mul_q30(ca, cb);
            p_sacb_reg <= mul_q30(sa, cb);
            p_casb_reg <= mul_q30(ca, sb);
            p_sasb_reg <= mul_q30(sa, sb);
            p_sacc_reg <= mul_q30(sa, cc);
            p_sasc_reg <= mul_q30(sa, sc);
            p_cacc_reg <= mul_q30(ca, cc);
            p_casc_reg <= mul_q30(ca, sc);
            p_cbsc_reg <= mul_q30(cb, sc);
            p_cbcc_reg <= mul_q30(cb, cc);
            nsb_reg    <= -sb;
            c1_sc_reg  <= sc;
            c1_cc_reg  <= cc;
        end
    end

    // Product stage 2: triple products.
    logic signed [XY_BITS-1:0] t01_reg, t02_reg, t11_reg, t12_reg;
    logic signed [XY_BITS-1:0] q00_reg, q10_reg, q20_reg, q21_reg, q22_reg;
    logic signed [XY_BITS-1:0] q01_reg, q02_reg, q11_reg, q12_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t01_reg <= mul_q30(p_casb_reg, c1_sc_reg);
            t02_reg <= mul_q30(p_casb_reg, c1_cc_reg);
            t11_reg <= mul_q30(p_sasb_reg, c1_sc_reg);
            t12_reg <= mul_q30(p_sasb_reg, c1_cc_reg);
            q01_reg <= p_sacc_reg;
            q02_reg <= p_sasc_reg;
            q11_reg <= p_cacc_reg;
            q12_reg <= p_casc_reg;
            q00_reg <= p_cacb_reg;
            q10_reg <= p_sacb_reg;
            q20_reg <= nsb_reg;
            q21_reg <= p_cbsc_reg;
            q22_reg <= p_cbcc_reg;
        end
    end

    // Sum stage.
    logic signed [8:0][XY_BITS:0] s_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_reg[0] <= (XY_BITS+1)'(q00_reg);
            s_reg[1] <= (XY_BITS+1)'(t01_reg) - (XY_BITS+1)'(q01_reg);
            s_reg[2] <= (XY_BITS+1)'(t02_reg) + (XY_BITS+1)'(q02_reg);
            s_reg[3] <= (XY_BITS+1)'(q10_reg);
            s_reg[4] <= (XY_BITS+1)'(t11_reg) + (XY_BITS+1)'(q11_reg);
            s_reg[5] <= (XY_BITS+1)'(t12_reg) - (XY_BITS+1)'(q12_reg);
            s_reg[6] <= (XY_BITS+1)'(q20_reg);
            s_reg[7] <= (XY_BITS+1)'(q21_reg);
            s_reg[8] <= (XY_BITS+1)'(q22_reg);
        end
    end

    // Round/saturate into the output register.
    ezyx_out_t out_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.r00 <= to_out(s_reg[0]);
            out_reg.r01 <= to_out(s_reg[1]);
            out_reg.r02 <= to_out(s_reg[2]);
            out_reg.r10 <= to_out(s_reg[3]);
            out_reg.r11 <= to_out(s_reg[4]);
            out_reg.r12 <= to_out(s_reg[5]);
            out_reg.r20 <= to_out(s_reg[6]);
            out_reg.r21 <= to_out(s_reg[7]);
            out_reg.r22 <= to_out(s_reg[8]);
        end
    end

    assign out_data = out_reg;

endmodule

// ----- design/ezyx_cordic_stage.sv -----
// ----------------------------------------------------------------------------
// ezyx_cordic_stage
// Pipelined CORDIC for the three angles, one registered rotation per stage.
// ----------------------------------------------------------------------------
module ezyx_cordic_stage
    import ezyx_pkg::*;
(
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [2:0][XY_BITS-1:0]   x_in,
    input  logic signed [2:0][XY_BITS-1:0]   y_in,
    input  logic signed [2:0][Z_BITS-1:0]    z_in,
    input  logic [2:0]                       flip_in,
    output logic signed [2:0][XY_BITS-1:0]   x_out,
    output logic signed [2:0][XY_BITS-1:0]   y_out,
    output logic [2:0]                       flip_out
);

    typedef struct packed {
        logic signed [XY_BITS-1:0] x;
        logic signed [XY_BITS-1:0] y;
        logic signed [Z_BITS-1:0]  z;
    } rot_t;

    rot_t       st_reg [CORDIC_STEPS][3];
    logic [2:0] fl_reg [CORDIC_STEPS];

    // One rotation; the step is a constant once the loops are unrolled.
    function automatic rot_t rotate(input rot_t a, input logic [4:0] s);
        rot_t                      r;
        logic signed [XY_BITS-1:0] dx;
        logic signed [XY_BITS-1:0] dy;
        logic signed [Z_BITS-1:0]  at;
        begin
            dx = a.y >>> s;
            dy = a.x >>> s;
            at = atan_lut(s);
            if (!a.z[Z_BITS-1])
            begin
                r.x = a.x - dx;
                r.y = a.y + dy;
                r.z = a.z - at;
            end
            else
            begin
                r.x = a.x + dx;
                r.y = a.y - dy;
                r.z = a.z + at;
            end
            rotate = r;
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                st_reg[0][k] <= rotate('{x: x_in[k], y: y_in[k], z: z_in[k]}, 5'd0);
                for (int s = 1; s < CORDIC_STEPS; s++)
                    st_reg[s][k] <= rotate(st_reg[s-1][k], 5'(s));
            end
            fl_reg[0] <= flip_in;
            for (int s = 1; s < CORDIC_STEPS; s++)
                fl_reg[s] <= fl_reg[s-1];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            x_out[k] = st_reg[CORDIC_STEPS-1][k].x;
            y_out[k] = st_reg[CORDIC_STEPS-1][k].y;
        end
        flip_out = fl_reg[CORDIC_STEPS-1];
    end

endmodule
